[design/gmma_pkg.sv]
package gmma_pkg;

    // Field widths fixed by the stream format.
    localparam int KEY_W   = 32;
    localparam int TEMP_W  = 16;
    localparam int CODE_W  = 8;
    localparam int DOM_W   = 7;
    localparam int INDEX_W = 16;

    // Input tdata: day_key, temperature, category_code, padded to 7 bytes.
    localparam int IN_DATA_W  = 56;
    // Output tdata: group_key, group_high, group_low, dominant_code,
    // group_index, padded to 11 bytes.
    localparam int OUT_DATA_W = 88;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the accepted sample, start the bin read
        logic update;     // apply the sample to the open group
        logic emit;       // load the open group summary into the output register
        logic emit_last;  // last_of_run value for that emitted result
        logic finish;     // end of series: close the group, clear the ordinal
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_pre;   // the sample closes a different open group
        logic eos;        // the sample ends the series
        logic open_after; // a group is open once the sample is applied
        logic out_free;   // the output register can take a result this cycle
    } t_dp_status;

endpackage

[design/gmma_ctrl.sv]
module gmma_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  gmma_pkg::t_dp_status  i_status,
    output gmma_pkg::t_dp_cmd     o_cmd
);
    import gmma_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_FLUSH  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Hold while the closed group cannot be handed to the output.
                if (!(i_status.need_pre && !i_status.out_free)) begin
                    o_cmd.update = 1'b1;
                    if (i_status.need_pre) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = !(i_status.eos && i_status.open_after);
                    end
                    if (i_status.eos && i_status.open_after) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_cmd.finish = i_status.eos;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.finish    = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/gmma_datapath.sv]
module gmma_datapath #(
    parameter int NUM_CODES      = 100,
    parameter int BIN_COUNT_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [gmma_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [gmma_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  gmma_pkg::t_dp_cmd                   i_cmd,
    output gmma_pkg::t_dp_status                o_status
);
    import gmma_pkg::*;

    localparam int ADDR_W = $clog2(NUM_CODES);
    localparam logic [CODE_W:0]         NUM_CODES_V = (CODE_W+1)'(NUM_CODES);
    localparam logic [BIN_COUNT_BITS-1:0] BIN_MAX   = '1;

    // Histogram bins; a bin whose valid bit is clear reads as zero.
    logic [BIN_COUNT_BITS-1:0] r_mem [NUM_CODES];
    logic [BIN_COUNT_BITS-1:0] r_rdata;
    logic [NUM_CODES-1:0]      r_valid;
    logic [NUM_CODES-1:0]      n_valid;

    // Captured sample.
    logic [KEY_W-1:0]          r_key;
    logic                      r_present;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [CODE_W-1:0]         r_code;
    logic                      r_eos;

    // Open group.
    logic                      r_open;
    logic [KEY_W-1:0]          r_open_key;
    logic signed [TEMP_W-1:0]  r_high;
    logic signed [TEMP_W-1:0]  r_low;
    logic [ADDR_W-1:0]         r_best_code;
    logic [BIN_COUNT_BITS-1:0] r_best_cnt;
    logic [INDEX_W-1:0]        r_groups;

    // Output register.
    logic                      r_out_valid;
    logic [KEY_W-1:0]          r_out_key;
    logic signed [TEMP_W-1:0]  r_out_high;
    logic signed [TEMP_W-1:0]  r_out_low;
    logic [DOM_W-1:0]          r_out_dom;
    logic [INDEX_W-1:0]        r_out_index;
    logic                      r_out_last;

    logic [CODE_W-1:0]         in_code;
    logic                      in_range_in;
    logic [ADDR_W-1:0]         in_addr;
    logic                      new_grp;
    logic                      in_range;
    logic [ADDR_W-1:0]         addr;
    logic [BIN_COUNT_BITS-1:0] cur_cnt;
    logic [BIN_COUNT_BITS-1:0] inc_cnt;
    logic                      counted;
    logic [ADDR_W-1:0]         base_code;
    logic [BIN_COUNT_BITS-1:0] base_cnt;
    logic                      take_best;

    assign in_code     = i_s_axis_tdata[KEY_W+TEMP_W +: CODE_W];
    assign in_range_in = {1'b0, in_code} < NUM_CODES_V;
    assign in_addr     = in_code[ADDR_W-1:0];

    assign new_grp  = r_present && (!r_open || (r_key != r_open_key));
    assign in_range = {1'b0, r_code} < NUM_CODES_V;
    assign addr     = r_code[ADDR_W-1:0];
    assign cur_cnt  = (!new_grp && in_range && r_valid[addr]) ? r_rdata : '0;
    assign inc_cnt  = cur_cnt + 1'b1;
    assign counted  = r_present && in_range && (cur_cnt != BIN_MAX);

    // Running argmax: the bumped bin wins if it passes the best count, or
    // ties it with a lower code.
    assign base_code = new_grp ? '0 : r_best_code;
    assign base_cnt  = new_grp ? '0 : r_best_cnt;
    assign take_best = counted && ((inc_cnt > base_cnt) ||
                                   ((inc_cnt == base_cnt) && (addr < base_code)));

    always_comb begin
        n_valid = new_grp ? '0 : r_valid;
        if (counted) begin
            n_valid[addr] = 1'b1;
        end
    end

    assign o_status.need_pre   = r_present && r_open && (r_key != r_open_key);
    assign o_status.eos        = r_eos;
    assign o_status.open_after = r_present || r_open;
    assign o_status.out_free   = !r_out_valid || i_m_axis_tready;

    // Bin memory: one read at capture, one write when the sample is applied.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && in_range_in) begin
            r_rdata <= r_mem[in_addr];
        end
        if (i_cmd.update && counted) begin
            r_mem[addr] <= inc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key     <= i_s_axis_tdata[KEY_W-1:0];
            r_temp    <= i_s_axis_tdata[KEY_W +: TEMP_W];
            r_code    <= in_code;
            r_present <= i_s_axis_tuser;
            r_eos     <= i_s_axis_tlast;
        end
        if (i_cmd.update && r_present) begin
            r_best_code <= take_best ? addr : base_code;
            r_best_cnt  <= take_best ? inc_cnt : base_cnt;
            if (new_grp) begin
                r_open_key <= r_key;
                r_high     <= r_temp;
                r_low      <= r_temp;
            end else begin
                if (r_temp > r_high) begin
                    r_high <= r_temp;
                end
                if (r_temp < r_low) begin
                    r_low <= r_temp;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out_key   <= r_open_key;
            r_out_high  <= r_high;
            r_out_low   <= r_low;
            r_out_dom   <= DOM_W'(r_best_code);
            r_out_index <= r_groups;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_groups    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update && r_present) begin
                r_valid <= n_valid;
            end
            if (i_cmd.finish) begin
                r_open   <= 1'b0;
                r_groups <= '0;
            end else begin
                if (i_cmd.update && r_present) begin
                    r_open <= 1'b1;
                end
                if (i_cmd.emit) begin
                    r_groups <= r_groups + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {1'b0, r_out_index, r_out_dom, r_out_low, r_out_high, r_out_key};

endmodule

[design/grouped_min_max_mode_aggregator_core.sv]
// A sample is captured in the idle state, starting the histogram bin read, and is
// applied in the update state, which loads a group it closes into the output
// register; a group left open by an end-of-series sample is flushed from the flush
// state. A new sample is taken only in the idle state, after the last one is done.
// Reset: i_rst_n is synchronous and active low; no group is open, the ordinal is
// zero and every histogram bin reads as zero at once, with no clearing pass.
module grouped_min_max_mode_aggregator_core #(
    parameter int NUM_CODES      = 100,
    parameter int BIN_COUNT_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // From bit 0: day_key[31:0], temperature[47:32], category_code[55:48].
    input  logic [gmma_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // key_present.
    input  logic                             i_s_axis_tuser,
    // end_of_series.
    input  logic                             i_s_axis_tlast,
    // Group summary stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // From bit 0: group_key[31:0], group_high[47:32], group_low[63:48],
    // dominant_code[70:64], group_index[86:71], zero pad[87].
    output logic [gmma_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // last_of_run.
    output logic                             o_m_axis_tlast
);
    import gmma_pkg::*;

    // The controller sequences each sample: capture (which also starts the
    // histogram bin read), then apply it, emitting the closed group when the
    // key changes, and a final flush state when the series ends with a group open. The
    // histogram lives in a memory inside the datapath; a bank of per-bin
    // valid bits is cleared at once whenever a new group opens, and the
    // most frequent code is tracked incrementally as bins are bumped, so a
    // summary never has to scan the bins.
    //
    // The output register separates the two sides: a new sample transaction
    // is taken while a summary still waits, and the controller only holds
    // when it must hand over a second summary before the first has left.
    t_dp_cmd    cmd;
    t_dp_status status;

    gmma_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    gmma_datapath #(
        .NUM_CODES      (NUM_CODES),
        .BIN_COUNT_BITS (BIN_COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule

[bench/tb_grouped_min_max_mode_aggregator_core.sv]
module tb_grouped_min_max_mode_aggregator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gmma_pkg::*;

    // The block is built with its default sizes, and the scoreboard below
    // mirrors them.
    localparam int NUM_CODES      = 100;
    localparam int BIN_COUNT_BITS = 8;
    localparam logic [BIN_COUNT_BITS-1:0] BIN_FULL = '1;

    // Stimulus sizes. The random series stop once this many keyed samples are
    // queued; the saturation group adds a little over five hundred more.
    localparam int RANDOM_KEYED = 240;
    localparam int QUEUE_DEPTH  = 16;

    // A quiet spell at the end catches any extra result.
    localparam int DRAIN_CYCLES = 12;
    // Watchdog limit: about 800 samples, with gaps on both sides and up to two
    // results each, stay well below it.
    localparam int CYCLE_LIMIT  = 50_000;
    // Neither side idles inside this window of cycles.
    localparam int QUIET_FIRST  = 300;
    localparam int QUIET_LAST   = 1100;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic [KEY_W-1:0]         day_key;
        logic                     key_present;
        logic signed [TEMP_W-1:0] temperature;
        logic [CODE_W-1:0]        code;
        logic                     end_of_series;
    } t_reading;

    typedef struct {
        logic [KEY_W-1:0]         key;
        logic signed [TEMP_W-1:0] high;
        logic signed [TEMP_W-1:0] low;
        logic [DOM_W-1:0]         dominant;
        logic [INDEX_W-1:0]       ordinal;
        logic                     last;
    } t_summary;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // From bit 0: day_key, temperature, category_code.
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    // key_present.
    logic                  i_s_axis_tuser  = 1'b0;
    // end_of_series.
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // From bit 0: group_key, group_high, group_low, dominant_code, group_index.
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // last_of_run.
    logic                  o_m_axis_tlast;

    // Scoreboard copy of the grouping state.
    logic                      group_is_open;
    logic [KEY_W-1:0]          current_key;
    logic signed [TEMP_W-1:0]  peak_high;
    logic signed [TEMP_W-1:0]  peak_low;
    logic [BIN_COUNT_BITS-1:0] code_count [NUM_CODES];
    logic [INDEX_W-1:0]        next_ordinal;

    t_reading pending_readings[$];
    t_reading reading_on_bus;
    t_summary summaries_due[$];

    int cycle_count       = 0;
    int error_count       = 0;
    int readings_taken    = 0;
    int keyless_taken     = 0;
    int series_closed     = 0;
    int summaries_checked = 0;
    int random_keyed      = 0;

    grouped_min_max_mode_aggregator_core #(
        .NUM_CODES      (NUM_CODES),
        .BIN_COUNT_BITS (BIN_COUNT_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoreboard model of the aggregator.
    // ------------------------------------------------------------------

    function automatic void clear_grouping();
        group_is_open = 1'b0;
        current_key   = '0;
        peak_high     = '0;
        peak_low      = '0;
        next_ordinal  = '0;
        foreach (code_count[c]) code_count[c] = '0;
    endfunction

    // Most frequent counted code; the strict compare makes the lowest code
    // win a tie, and an empty histogram yields code 0.
    function automatic logic [DOM_W-1:0] busiest_code();
        int best;
        int best_count;
        best       = 0;
        best_count = 0;
        for (int c = 0; c < NUM_CODES; c++) begin
            if (code_count[c] > best_count) begin
                best_count = code_count[c];
                best       = c;
            end
        end
        return best[DOM_W-1:0];
    endfunction

    function automatic void close_group();
        t_summary s;
        s.key      = current_key;
        s.high     = peak_high;
        s.low      = peak_low;
        s.dominant = busiest_code();
        s.ordinal  = next_ordinal;
        s.last     = 1'b0;
        summaries_due.push_back(s);
        next_ordinal = next_ordinal + 1'b1;
    endfunction

    // Works out the summaries that one accepted sample releases.
    function automatic void apply_reading(t_reading r);
        int produced;
        produced = 0;
        if (r.key_present) begin
            if (!group_is_open || r.day_key != current_key) begin
                if (group_is_open) begin
                    close_group();
                    produced++;
                end
                group_is_open = 1'b1;
                current_key   = r.day_key;
                peak_high     = r.temperature;
                peak_low      = r.temperature;
                foreach (code_count[c]) code_count[c] = '0;
            end else begin
                if (r.temperature > peak_high) peak_high = r.temperature;
                if (r.temperature < peak_low) peak_low = r.temperature;
            end
            // Codes outside the histogram are dropped, and full bins stick.
            if (r.code < NUM_CODES && code_count[r.code] != BIN_FULL)
                code_count[r.code] = code_count[r.code] + 1'b1;
        end
        // End of series flushes whatever is open, keyed sample or not.
        if (r.end_of_series) begin
            if (group_is_open) begin
                close_group();
                produced++;
            end
            group_is_open = 1'b0;
            next_ordinal  = '0;
        end
        if (produced > 0)
            summaries_due[summaries_due.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------

    function automatic bit field_differs(string name, logic signed [63:0] want,
                                         logic signed [63:0] got);
        if (got === want) return 1'b0;
        if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b1;
    endfunction

    function automatic void check_summary();
        t_summary want;
        bit       bad;
        if (summaries_due.size() == 0) begin
            if (error_count < MAX_REPORTS)
                $display("%0t: unexpected summary transaction, expected none, actual tdata %h",
                         $time, o_m_axis_tdata);
            error_count++;
            return;
        end
        want = summaries_due.pop_front();
        bad  = field_differs("group_key", want.key, o_m_axis_tdata[31:0])
             | field_differs("group_high", want.high, $signed(o_m_axis_tdata[47:32]))
             | field_differs("group_low", want.low, $signed(o_m_axis_tdata[63:48]))
             | field_differs("dominant_code", want.dominant, o_m_axis_tdata[70:64])
             | field_differs("group_index", want.ordinal, o_m_axis_tdata[86:71])
             | field_differs("last_of_run", want.last, o_m_axis_tlast);
        if (bad) error_count++;
        summaries_checked++;
    endfunction

    // Random back-pressure and gaps, switched off inside the quiet window.
    function automatic bit take_a_break();
        return (cycle_count < QUIET_FIRST || cycle_count >= QUIET_LAST)
               && $urandom_range(99) < 6;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: every accepted transaction goes into the scoreboard
    // at the same edge, and the next queued sample is presented right away
    // unless a random gap is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_reading(reading_on_bus);
                readings_taken++;
                if (!reading_on_bus.key_present) keyless_taken++;
                if (reading_on_bus.end_of_series) series_closed++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_readings.size() != 0 && !take_a_break()) begin
                    reading_on_bus = pending_readings.pop_front();
                    i_s_axis_tdata <= {reading_on_bus.code, reading_on_bus.temperature,
                                       reading_on_bus.day_key};
                    i_s_axis_tuser  <= reading_on_bus.key_present;
                    i_s_axis_tlast  <= reading_on_bus.end_of_series;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Summary monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_summary();
            i_m_axis_tready <= !take_a_break();
        end
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d summaries outstanding.",
                     cycle_count, summaries_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // The queue is kept short so the long runs need no big buffer.
    task automatic queue_reading(logic [KEY_W-1:0] key, logic present,
                                 logic [TEMP_W-1:0] temp, logic [CODE_W-1:0] code,
                                 logic eos);
        t_reading r;
        while (pending_readings.size() >= QUEUE_DEPTH) @(posedge i_clk);
        r.day_key       = key;
        r.key_present   = present;
        r.temperature   = temp;
        r.code          = code;
        r.end_of_series = eos;
        pending_readings.push_back(r);
    endtask

    task automatic directed_readings();
        // A keyless sample at the very start must not open or emit anything,
        // nor must an end of series with no group open.
        queue_reading(32'hFFFF_FFFF, 1'b0, 16'sh7FFF, 8'd5, 1'b0);
        queue_reading(32'h0000_0000, 1'b0, 16'sh8000, 8'd255, 1'b1);
        // Key 0 with both temperature extremes; no code lands in range, so
        // the dominant code comes out as 0. The keyless sample in between
        // carries a code that must not be counted.
        queue_reading(32'h0000_0000, 1'b1, 16'sh8000, 8'd255, 1'b0);
        queue_reading(32'h0000_0000, 1'b1, 16'sh7FFF, 8'd100, 1'b0);
        queue_reading(32'h0000_0000, 1'b0, 16'sh0000, 8'd3, 1'b0);
        queue_reading(32'h0000_0000, 1'b1, 16'sd100, 8'd200, 1'b0);
        // Key change; codes 99 and 7 tie and the lower one must win.
        queue_reading(32'hFFFF_FFFF, 1'b1, -16'sd1, 8'd99, 1'b0);
        queue_reading(32'hFFFF_FFFF, 1'b1, 16'sd5, 8'd7, 1'b0);
        // Key change and end of series on one sample: two results.
        queue_reading(32'h1234_5678, 1'b1, 16'sd0, 8'd0, 1'b1);
        queue_reading(32'h0000_0001, 1'b0, 16'sd0, 8'd0, 1'b1);
        // A keyless end of series still flushes the open group.
        queue_reading(32'hA5A5_A5A5, 1'b1, 16'sd1234, 8'd42, 1'b0);
        queue_reading(32'h5A5A_5A5A, 1'b0, 16'sh7FFF, 8'd42, 1'b1);
        // End of series on a sample that extends the open group.
        queue_reading(32'h0000_0001, 1'b1, -16'sd5, 8'd0, 1'b0);
        queue_reading(32'h0000_0001, 1'b1, 16'sd9, 8'd0, 1'b1);
        // Fast key changes, and a key that returns after another.
        queue_reading(32'h0000_0002, 1'b1, 16'sd10, 8'd50, 1'b0);
        queue_reading(32'h0000_0003, 1'b1, 16'sd20, 8'd50, 1'b0);
        queue_reading(32'h0000_0002, 1'b1, 16'sd30, 8'd98, 1'b0);
        queue_reading(32'h0000_0002, 1'b1, -16'sd30, 8'd99, 1'b1);
    endtask

    // One series of groups with random content. Most series are closed by an
    // end of series on the last sample or on a trailing keyless sample; some
    // stay open, so their ordinal carries into the next series.
    task automatic random_series();
        int               group_total;
        int               run_len;
        int               ending;
        int               base_temp;
        int               temp;
        logic [KEY_W-1:0] key;
        logic [CODE_W-1:0] code;
        logic             eos;
        group_total = $urandom_range(1, 6);
        ending      = $urandom_range(0, 9);
        key         = $urandom;
        for (int g = 0; g < group_total; g++) begin
            case ($urandom_range(0, 3))
                0: key = $urandom;
                1: key = key + 1'b1;
                2: key = $urandom_range(0, 3);
                default: key = ~key;
            endcase
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 5);
            base_temp = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(0, 11) == 0)
                    queue_reading($urandom, 1'b0, TEMP_W'($urandom), CODE_W'($urandom),
                                  1'b0);
                temp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                                   : base_temp + $urandom_range(0, 60) - 30;
                // Mostly a few low or high codes so that counts build up and
                // tie; now and then anything, out of range included.
                if ($urandom_range(0, 4) == 0)
                    code = CODE_W'($urandom_range(0, 255));
                else if ($urandom_range(0, 1) == 0)
                    code = CODE_W'($urandom_range(0, 5));
                else
                    code = CODE_W'($urandom_range(94, 99));
                eos = (ending <= 5) && (g == group_total - 1) && (i == run_len - 1);
                queue_reading(key, 1'b1, temp[TEMP_W-1:0], code, eos);
                random_keyed++;
            end
        end
        if (ending == 6 || ending == 7)
            queue_reading($urandom, 1'b0, TEMP_W'($urandom), CODE_W'($urandom), 1'b1);
    endtask

    // One long group in which two codes both reach the bin limit. Once both
    // bins are full they tie, so the lower code must win even where the
    // higher one was seen more often.
    task automatic saturation_group();
        int                left_low;
        int                left_high;
        logic [CODE_W-1:0] low_code;
        logic [CODE_W-1:0] high_code;
        logic [KEY_W-1:0]  key;
        low_code  = CODE_W'($urandom_range(0, 49));
        high_code = CODE_W'($urandom_range(50, 99));
        left_low  = 255 + $urandom_range(0, 4);
        left_high = 256 + $urandom_range(0, 20);
        key       = $urandom;
        queue_reading($urandom, 1'b0, TEMP_W'($urandom), CODE_W'($urandom), 1'b1);
        while (left_low + left_high > 0) begin
            if (left_high == 0 || (left_low != 0 && $urandom_range(0, 1) == 0)) begin
                queue_reading(key, 1'b1, TEMP_W'($urandom), low_code,
                              left_low + left_high == 1);
                left_low--;
            end else begin
                queue_reading(key, 1'b1, TEMP_W'($urandom), high_code,
                              left_low + left_high == 1);
                left_high--;
            end
        end
    endtask

    initial begin
        clear_grouping();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_readings();
        while (random_keyed < RANDOM_KEYED) random_series();
        saturation_group();

        // Let every sample go through, then every summary, then a short
        // quiet spell to catch anything extra.
        while (pending_readings.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (summaries_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d sample transactions (%0d keyless) in %0d closed series over %0d cycles.",
                 readings_taken, keyless_taken, series_closed, cycle_count);
        $display("Checked %0d group summaries, incl. saturated bins; %0d bad.",
                 summaries_checked, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[grouped_min_max_mode_aggregator_core.f]
design/gmma_pkg.sv
design/gmma_ctrl.sv
design/gmma_datapath.sv
design/grouped_min_max_mode_aggregator_core.sv
bench/tb_grouped_min_max_mode_aggregator_core.sv
